// ===== design/rpn_pkg.sv =====
// shared opcodes, widths and defaults for the rpn calculator
package rpn_pkg;

  localparam int DEF_STACK_DEPTH   = 128;
  localparam int DEF_FRACTION_BITS = 16;
  localparam int DATA_W            = 32;
  localparam int OP_W              = 3;

  typedef logic [OP_W-1:0] opcode_t;
  typedef logic signed [DATA_W-1:0] qnum_t;

  localparam opcode_t OP_PUSH  = 3'd0;
  localparam opcode_t OP_ADD   = 3'd1;
  localparam opcode_t OP_SUB   = 3'd2;
  localparam opcode_t OP_MUL   = 3'd3;
  localparam opcode_t OP_DIV   = 3'd4;
  localparam opcode_t OP_REM   = 3'd5;
  localparam opcode_t OP_PRINT = 3'd6;

  localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

endpackage

// ===== design/rpn_if.sv =====
// request and response channel interfaces of the rpn calculator
interface rpn_req_if;
  import rpn_pkg::*;
  logic    valid;
  logic    ready;
  opcode_t opcode;
  qnum_t   number;
  modport source (output valid, output opcode, output number, input ready);
  modport sink (input valid, input opcode, input number, output ready);
endinterface

interface rpn_rsp_if;
  import rpn_pkg::*;
  logic  valid;
  logic  ready;
  qnum_t value;
  logic  printed;
  logic  divide_by_zero;
  logic  stack_full;
  logic  stack_empty;
  logic  unknown_op;
  logic  saturated;
  modport source (output valid, output value, output printed, output divide_by_zero,
                  output stack_full, output stack_empty, output unknown_op,
                  output saturated, input ready);
  modport sink (input valid, input value, input printed, input divide_by_zero,
                input stack_full, input stack_empty, input unknown_op,
                input saturated, output ready);
endinterface

// ===== design/rpn_ram.sv =====
// generic single-write, single-read ram with registered read data
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/rpn_stack_calculator.sv =====
// rpn stack calculator: sequencer, operand stack ram and shared divider
// divide and remainder run through the shared radix-2 divider
// one request at a time; request ready only while idle, response held until taken
// synchronous active-high reset empties the stack and returns to idle
module rpn_stack_calculator #(
  parameter int STACK_DEPTH   = rpn_pkg::DEF_STACK_DEPTH,
  parameter int FRACTION_BITS = rpn_pkg::DEF_FRACTION_BITS
) (
  input logic        clk,
  input logic        rst,
  rpn_req_if.sink    req,
  rpn_rsp_if.source  rsp
);
  import rpn_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int DW = DATA_W + FRACTION_BITS;
  localparam int SW = $clog2(DW + 1);
  localparam logic signed [63:0] BIAS = (64'sd1 <<< FRACTION_BITS) - 64'sd1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_POPB  = 4'd1;
  localparam logic [3:0] S_WAITB = 4'd2;
  localparam logic [3:0] S_CHKB  = 4'd3;
  localparam logic [3:0] S_POPA  = 4'd4;
  localparam logic [3:0] S_WAITA = 4'd5;
  localparam logic [3:0] S_EXEC  = 4'd6;
  localparam logic [3:0] S_MSH   = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_DFIN  = 4'd9;
  localparam logic [3:0] S_PUSH  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]        state;
  opcode_t           op;
  qnum_t             a, b, value;
  logic [CW-1:0]     count, cnt_m1;
  logic signed [63:0] res, prod, clamped64;
  logic [DW-1:0]     dq;
  logic [31:0]       rem, dvs, rem_next, a_mag, b_mag;
  logic [SW-1:0]     step;
  logic              neg;
  logic              printed, dz, full, empty, unk, sat;
  logic              has_room, sat_hi, sat_lo, ge;
  logic [32:0]       trial, diff;
  logic              we;
  logic [31:0]       wdata, rdata;
  logic [AW-1:0]     raddr;

  assign cnt_m1   = count - CW'(1);
  assign raddr    = cnt_m1[AW-1:0];
  assign has_room = count < CW'(STACK_DEPTH);
  assign prod     = a * b;
  assign a_mag    = a[31] ? (~a + 32'd1) : a;
  assign b_mag    = b[31] ? (~b + 32'd1) : b;

  assign sat_hi    = res > Q_MAX;
  assign sat_lo    = res < Q_MIN;
  assign clamped64 = sat_hi ? Q_MAX : (sat_lo ? Q_MIN : res);

  // restoring divider step
  assign trial    = {rem, dq[DW-1]};
  assign diff     = trial - {1'b0, dvs};
  assign ge       = trial >= {1'b0, dvs};
  assign rem_next = ge ? diff[31:0] : trial[31:0];

  assign we = (state == S_IDLE && req.valid && req.opcode == OP_PUSH && has_room)
           || (state == S_PUSH && has_room);
  assign wdata = (state == S_PUSH) ? clamped64[31:0] : req.number;

  rpn_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH), .AW(AW)) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (count[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      printed <= 1'b0;
      dz      <= 1'b0;
      full    <= 1'b0;
      empty   <= 1'b0;
      unk     <= 1'b0;
      sat     <= 1'b0;
      value   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op      <= req.opcode;
            value   <= '0;
            printed <= 1'b0;
            dz      <= 1'b0;
            full    <= 1'b0;
            empty   <= 1'b0;
            unk     <= 1'b0;
            sat     <= 1'b0;
            case (req.opcode)
              OP_PUSH: begin
                if (has_room) begin
                  count <= count + CW'(1);
                end else begin
                  full <= 1'b1;
                end
                state <= S_OUT;
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_PRINT: state <= S_POPB;
              default: begin
                unk   <= 1'b1;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_POPB: begin
          if (count != '0) begin
            count <= cnt_m1;
            state <= S_WAITB;
          end else begin
            b     <= '0;
            empty <= 1'b1;
            state <= S_CHKB;
          end
        end
        S_WAITB: begin
          b     <= rdata;
          state <= S_CHKB;
        end
        S_CHKB: begin
          if (op == OP_PRINT) begin
            value   <= b;
            printed <= 1'b1;
            state   <= S_OUT;
          end else if ((op == OP_DIV || op == OP_REM) && b == '0) begin
            dz    <= 1'b1;
            state <= S_OUT;
          end else begin
            state <= S_POPA;
          end
        end
        S_POPA: begin
          if (count != '0) begin
            count <= cnt_m1;
            state <= S_WAITA;
          end else begin
            a     <= '0;
            empty <= 1'b1;
            state <= S_EXEC;
          end
        end
        S_WAITA: begin
          a     <= rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          case (op)
            OP_ADD: begin
              res   <= 64'(a) + 64'(b);
              state <= S_PUSH;
            end
            OP_SUB: begin
              res   <= 64'(a) - 64'(b);
              state <= S_PUSH;
            end
            OP_MUL: begin
              res   <= prod;
              state <= S_MSH;
            end
            default: begin
              // divide scales the dividend by one unit, remainder uses it as is
              dq    <= (op == OP_DIV) ? (DW'(a_mag) << FRACTION_BITS) : DW'(a_mag);
              rem   <= '0;
              dvs   <= b_mag;
              step  <= SW'(DW);
              neg   <= (op == OP_DIV) ? (a[31] ^ b[31]) : a[31];
              state <= S_DIV;
            end
          endcase
        end
        S_MSH: begin
          // truncate toward zero
          res   <= (res + (res[63] ? BIAS : 64'sd0)) >>> FRACTION_BITS;
          state <= S_PUSH;
        end
        S_DIV: begin
          rem  <= rem_next;
          dq   <= {dq[DW-2:0], ge};
          step <= step - SW'(1);
          if (step == SW'(1)) begin
            state <= S_DFIN;
          end
        end
        S_DFIN: begin
          if (op == OP_DIV) begin
            res <= neg ? -$signed(64'(dq)) : $signed(64'(dq));
          end else begin
            res <= neg ? -$signed(64'(rem)) : $signed(64'(rem));
          end
          state <= S_PUSH;
        end
        S_PUSH: begin
          sat <= sat_hi | sat_lo;
          if (has_room) begin
            count <= count + CW'(1);
          end else begin
            full <= 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = (state == S_OUT);
  assign rsp.value          = value;
  assign rsp.printed        = printed;
  assign rsp.divide_by_zero = dz;
  assign rsp.stack_full     = full;
  assign rsp.stack_empty    = empty;
  assign rsp.unknown_op     = unk;
  assign rsp.saturated      = sat;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.opcode == OP_PUSH && has_room)
    |=> count == $past(count) + CW'(1))
    else $error("push did not grow the stack");

  a_flag_excl: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(printed && dz) && !(unk && (printed || dz || empty || sat)))
    else $error("conflicting response flags");

  a_dz_keeps: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHKB && dz == 1'b0 && (op == OP_DIV || op == OP_REM) && b == '0)
    |=> $stable(count))
    else $error("zero divisor changed the stack");
`endif
endmodule
